// File: sv/cpl_pkg.sv
// shared types, operator codes and helper functions for the cigar position locator
package cpl_pkg;

  // cigar operator codes
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_I  = 4'd1;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_H  = 4'd5;
  localparam logic [3:0] OP_P  = 4'd6;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  // elements at this index or beyond are ignored
  localparam logic [15:0] MAX_CIGAR_OPS = 16'd65535;

  // read cursor saturation value
  localparam logic [30:0] READ_MAX = 31'h7FFF_FFFF;

  // saturation bounds of the read offset, at the working width
  localparam logic signed [33:0] OFFSET_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] OFFSET_MIN = -34'sh0_8000_0000;

  // one incoming cigar element beat
  typedef struct packed {
    logic [3:0]  cigar_op;
    logic [27:0] op_length;
    logic        first_element;
    logic        last_element;
    logic [30:0] align_start;
    logic [30:0] target_pos;
  } in_t;

  // one result beat
  typedef struct packed {
    logic               found;
    logic signed [31:0] read_offset;
    logic [15:0]        element_index;
    logic signed [31:0] element_start;
    logic [3:0]         element_op;
    logic               is_deletion;
    logic               before_deletion;
    logic               before_insertion;
    logic               before_soft_clip;
    logic               after_soft_clip;
    logic [27:0]        next_indel_length;
  } out_t;

  // operator consumes reference bases
  function automatic logic uses_ref(input logic [3:0] op);
    return (op == OP_M) || (op == OP_D) || (op == OP_N) || (op == OP_EQ) || (op == OP_X);
  endfunction

  // operator consumes read bases
  function automatic logic uses_read(input logic [3:0] op);
    return (op == OP_M) || (op == OP_I) || (op == OP_S) || (op == OP_EQ) || (op == OP_X);
  endfunction

  // operator lies on the genome
  function automatic logic on_genome(input logic [3:0] op);
    return (op == OP_M) || (op == OP_D) || (op == OP_EQ) || (op == OP_X);
  endfunction

endpackage

// File: sv/cpl_tracker.sv
// per-read cursors, hit capture and neighbour flag tracking
module cpl_tracker (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  cpl_pkg::in_t item,
  output cpl_pkg::out_t result
);

  // running state of the current read
  logic [31:0] ref_cursor, ref_cursor_next;
  logic [30:0] read_cursor, read_cursor_next;
  logic [30:0] target_reg, target_reg_next;
  logic [15:0] element_counter, element_counter_next;
  logic        hit_found, hit_found_next;
  logic [3:0]  hit_op, hit_op_next;
  logic [31:0] hit_start, hit_start_next;
  logic [31:0] hit_offset, hit_offset_next;
  logic [15:0] hit_index, hit_index_next;
  logic        hit_at_end, hit_at_end_next;
  logic [3:0]  previous_op, previous_op_next;
  logic [4:0]  neighbour_flags, neighbour_flags_next;
  logic        genome_search_pending, genome_search_pending_next;
  logic [27:0] indel_length, indel_length_next;

  // datapath temporaries
  logic [31:0]        len32;
  logic [31:0]        cur;
  logic [31:0]        rd_sum;
  logic [30:0]        rd;
  logic [31:0]        cs;
  logic signed [33:0] off_wide;
  logic signed [33:0] off_adj;
  logic [15:0]        idx;

  assign len32 = {4'b0, item.op_length};

  // next state for the element in the input register
  always_comb begin
    // a first element restarts the read
    if (item.first_element) begin
      ref_cursor_next            = {1'b0, item.align_start};
      read_cursor_next           = '0;
      target_reg_next            = item.target_pos;
      element_counter_next       = '0;
      hit_found_next             = 1'b0;
      hit_op_next                = '0;
      hit_start_next             = '0;
      hit_offset_next            = '0;
      hit_index_next             = '0;
      hit_at_end_next            = 1'b0;
      previous_op_next           = '0;
      neighbour_flags_next       = '0;
      genome_search_pending_next = 1'b0;
      indel_length_next          = '0;
    end else begin
      ref_cursor_next            = ref_cursor;
      read_cursor_next           = read_cursor;
      target_reg_next            = target_reg;
      element_counter_next       = element_counter;
      hit_found_next             = hit_found;
      hit_op_next                = hit_op;
      hit_start_next             = hit_start;
      hit_offset_next            = hit_offset;
      hit_index_next             = hit_index;
      hit_at_end_next            = hit_at_end;
      previous_op_next           = previous_op;
      neighbour_flags_next       = neighbour_flags;
      genome_search_pending_next = genome_search_pending;
      indel_length_next          = indel_length;
    end

    idx = element_counter_next;

    // cursor advance, with saturation of the read side
    cur    = ref_cursor_next + (cpl_pkg::uses_ref(item.cigar_op) ? len32 : 32'd0);
    rd_sum = {1'b0, read_cursor_next} + (cpl_pkg::uses_read(item.cigar_op) ? len32 : 32'd0);
    rd     = rd_sum[31] ? cpl_pkg::READ_MAX : rd_sum[30:0];
    cs     = cur - len32;

    // offset of the target within the read, before saturation
    off_adj  = (item.op_length != '0)
               ? ($signed({3'b0, target_reg_next}) - $signed({{2{cs[31]}}, cs}))
               : 34'sd0;
    off_wide = $signed({3'b0, rd}) - $signed({6'b0, item.op_length}) + off_adj;

    if (element_counter_next != cpl_pkg::MAX_CIGAR_OPS) begin
      element_counter_next = element_counter_next + 16'd1;
      priority if (!hit_found_next) begin
        ref_cursor_next  = cur;
        read_cursor_next = rd;
        // capture the element whose reference end passes the target
        if (cur > {1'b0, target_reg_next}) begin
          hit_found_next = 1'b1;
          hit_op_next    = item.cigar_op;
          hit_index_next = idx;
          hit_start_next = cs;
          if (off_wide > cpl_pkg::OFFSET_MAX) begin
            hit_offset_next = cpl_pkg::OFFSET_MAX[31:0];
          end else if (off_wide < cpl_pkg::OFFSET_MIN) begin
            hit_offset_next = cpl_pkg::OFFSET_MIN[31:0];
          end else begin
            hit_offset_next = off_wide[31:0];
          end
          hit_at_end_next = (cur == {1'b0, target_reg_next} + 32'd1);
          neighbour_flags_next    = '0;
          neighbour_flags_next[0] = (item.cigar_op == cpl_pkg::OP_D);
          neighbour_flags_next[4] = (idx != '0) && (previous_op_next == cpl_pkg::OP_S)
                                    && (cs == {1'b0, target_reg_next});
        end
      end else if (idx == hit_index_next + 16'd1) begin
        // element right after the hit
        if (hit_at_end_next) begin
          if (item.cigar_op == cpl_pkg::OP_D && hit_op_next != cpl_pkg::OP_D) begin
            neighbour_flags_next[1] = 1'b1;
          end
          if (item.cigar_op == cpl_pkg::OP_I) begin
            neighbour_flags_next[2] = 1'b1;
            indel_length_next       = item.op_length;
          end
          if (item.cigar_op == cpl_pkg::OP_S) begin
            neighbour_flags_next[3]    = 1'b1;
            genome_search_pending_next = 1'b1;
          end
        end
      end else begin
        // first on-genome element after a soft clip
        if (genome_search_pending_next && cpl_pkg::on_genome(item.cigar_op)) begin
          indel_length_next          = item.op_length;
          genome_search_pending_next = 1'b0;
        end
      end
      previous_op_next = item.cigar_op;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_cursor            <= '0;
      read_cursor           <= '0;
      target_reg            <= '0;
      element_counter       <= '0;
      hit_found             <= 1'b0;
      hit_op                <= '0;
      hit_start             <= '0;
      hit_offset            <= '0;
      hit_index             <= '0;
      hit_at_end            <= 1'b0;
      previous_op           <= '0;
      neighbour_flags       <= '0;
      genome_search_pending <= 1'b0;
      indel_length          <= '0;
    end else if (step) begin
      ref_cursor            <= ref_cursor_next;
      read_cursor           <= read_cursor_next;
      target_reg            <= target_reg_next;
      element_counter       <= element_counter_next;
      hit_found             <= hit_found_next;
      hit_op                <= hit_op_next;
      hit_start             <= hit_start_next;
      hit_offset            <= hit_offset_next;
      hit_index             <= hit_index_next;
      hit_at_end            <= hit_at_end_next;
      previous_op           <= previous_op_next;
      neighbour_flags       <= neighbour_flags_next;
      genome_search_pending <= genome_search_pending_next;
      indel_length          <= indel_length_next;
    end
  end

  // result as it stands after this element, all zero when nothing was found
  always_comb begin
    result = '0;
    if (hit_found_next) begin
      result.found             = 1'b1;
      result.read_offset       = hit_offset_next;
      result.element_index     = hit_index_next;
      result.element_start     = hit_start_next;
      result.element_op        = hit_op_next;
      result.is_deletion       = neighbour_flags_next[0];
      result.before_deletion   = neighbour_flags_next[1];
      result.before_insertion  = neighbour_flags_next[2];
      result.before_soft_clip  = neighbour_flags_next[3];
      result.after_soft_clip   = neighbour_flags_next[4];
      result.next_indel_length = indel_length_next;
    end
  end

endmodule

// File: sv/cigar_position_locator.sv
// Top level of the cigar position locator.
// Input channel: item_valid / item_stall / item carry one cigar element per beat,
// in read order. The first element of a read carries first_element, the alignment
// start and the target reference position; the element with last_element set
// produces exactly one result beat.
// Output channel: result_valid / result_stall / result carry one beat per read:
// found, read offset, covering element index, start and operator, the neighbour
// flags and the next indel length. With found low every other field is zero.
// Flow: an accepted element is registered in the input register, where the cursor
// logic processes it; its result is then registered in the result register and offered.
// Throughput: one element per cycle unless a last element waits on a held result,
// set by the cursor update loop between the input register and the tracker state.
// Stall: while result_stall holds a result, elements without last_element keep
// flowing; an element with last_element waits in the input register and
// item_stall rises until the result register frees.
// Reset: clears the cursors, the captured hit and the valid bits of both channel
// registers; a read that starts without a first element begins from zero cursors.
module cigar_position_locator (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  cpl_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output cpl_pkg::out_t result
);

  // input register
  logic          held;
  cpl_pkg::in_t  held_item;
  logic          out_free;
  logic          step;
  cpl_pkg::out_t step_result;

  assign out_free   = !result_valid || !result_stall;
  assign step       = held && (!held_item.last_element || out_free);
  assign item_stall = held && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!item_stall) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      held_item <= item;
    end
  end

  // cursor and hit tracking
  cpl_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .result (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= step && held_item.last_element;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && held_item.last_element) begin
      result <= step_result;
    end
  end

endmodule
